// ===== design/bbr_pkg.sv =====
// Shared types, register and operation codes, and the raster operation function
// for the clipped bitmap blit block. No dependencies.
`default_nettype none

package bbr_pkg;

  // Default storage geometry.
  localparam int DEF_MAX_ROWS      = 256;
  localparam int DEF_MAX_ROW_BYTES = 32;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_START_ROW        = 3'd0;
  localparam logic [2:0] REG_START_COL_PIXELS = 3'd1;
  localparam logic [2:0] REG_RASTER_OP        = 3'd2;
  localparam logic [2:0] REG_TARGET_ROWS      = 3'd3;
  localparam logic [2:0] REG_TARGET_ROW_BYTES = 3'd4;

  // Raster operation codes.
  localparam logic [1:0] ROP_REPLACE = 2'd0;
  localparam logic [1:0] ROP_AND     = 2'd1;
  localparam logic [1:0] ROP_OR      = 2'd2;

  // Item kinds.
  localparam logic KIND_DRAW = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Value of a cleared byte.
  localparam logic [7:0] WHITE = 8'hFF;

  // Reset values of the bound registers.
  localparam logic [8:0] RST_TARGET_ROWS      = 9'd256;
  localparam logic [5:0] RST_TARGET_ROW_BYTES = 6'd32;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [7:0] start_row;
    logic [7:0] start_col_pixels;
    logic [1:0] raster_op;
    logic [8:0] target_rows;
    logic [5:0] target_row_bytes;
  } cfg_t;

  // Combine a source byte with the stored byte. The unused code keeps the stored byte.
  function automatic logic [7:0] rop_apply(input logic [1:0] op, input logic [7:0] stored,
                                           input logic [7:0] pix);
    logic [7:0] res;
    case (op)
      ROP_REPLACE: res = pix;
      ROP_AND:     res = stored & pix;
      ROP_OR:      res = stored | pix;
      default:     res = stored;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/bbr_regs.sv =====
// APB-style configuration registers of the blit block.
// Depends on bbr_pkg for the register codes and the cfg_t struct.
`default_nettype none

module bbr_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bbr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [bbr_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [bbr_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                   pready,
  output bbr_pkg::cfg_t                          cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes in the access cycle; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_row        <= '0;
      cfg.start_col_pixels <= '0;
      cfg.raster_op        <= bbr_pkg::ROP_REPLACE;
      cfg.target_rows      <= bbr_pkg::RST_TARGET_ROWS;
      cfg.target_row_bytes <= bbr_pkg::RST_TARGET_ROW_BYTES;
    end else if (wr) begin
      unique case (idx)
        bbr_pkg::REG_START_ROW:        cfg.start_row        <= pwdata[7:0];
        bbr_pkg::REG_START_COL_PIXELS: cfg.start_col_pixels <= pwdata[7:0];
        bbr_pkg::REG_RASTER_OP:        cfg.raster_op        <= pwdata[1:0];
        bbr_pkg::REG_TARGET_ROWS:      cfg.target_rows      <= pwdata[8:0];
        bbr_pkg::REG_TARGET_ROW_BYTES: cfg.target_row_bytes <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (idx)
      bbr_pkg::REG_START_ROW:        prdata = {24'd0, cfg.start_row};
      bbr_pkg::REG_START_COL_PIXELS: prdata = {24'd0, cfg.start_col_pixels};
      bbr_pkg::REG_RASTER_OP:        prdata = {30'd0, cfg.raster_op};
      bbr_pkg::REG_TARGET_ROWS:      prdata = {23'd0, cfg.target_rows};
      bbr_pkg::REG_TARGET_ROW_BYTES: prdata = {26'd0, cfg.target_row_bytes};
      default:                       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/bbr_place.sv =====
// Target placement and clipping for one item: offsets, bound checks, store address.
// Depends on bbr_pkg for the cfg_t struct and the item kind codes.
`default_nettype none

module bbr_place #(
  parameter int MAX_ROWS      = bbr_pkg::DEF_MAX_ROWS,
  parameter int MAX_ROW_BYTES = bbr_pkg::DEF_MAX_ROW_BYTES,
  parameter int RAW           = 8,
  parameter int CAW           = 5
) (
  input  wire logic          kind,
  input  wire logic [7:0]    row,
  input  wire logic [4:0]    byte_col,
  input  wire bbr_pkg::cfg_t cfg,
  output logic               clip,
  output logic [RAW+CAW-1:0] addr
);

  localparam logic [12:0] ROWS_LIM = 13'(MAX_ROWS);
  localparam logic [9:0]  COLS_LIM = 10'(MAX_ROW_BYTES);

  logic [8:0]  trow;
  logic [5:0]  tcol;
  logic [12:0] trow_w;
  logic [9:0]  tcol_w;
  logic [12:0] rows_req;
  logic [9:0]  cols_req;
  logic [12:0] rows_bound;
  logic [9:0]  cols_bound;

  // Draw items are shifted by the start offsets; read items address the target directly.
  always_comb begin
    if (kind == bbr_pkg::KIND_DRAW) begin
      trow = {1'b0, row} + {1'b0, cfg.start_row};
      tcol = {1'b0, byte_col} + {1'b0, cfg.start_col_pixels[7:3]};
    end else begin
      trow = {1'b0, row};
      tcol = {1'b0, byte_col};
    end
  end

  // Bounds in use, limited to the storage size.
  assign rows_req   = {4'd0, cfg.target_rows};
  assign cols_req   = {4'd0, cfg.target_row_bytes};
  assign rows_bound = (rows_req > ROWS_LIM) ? ROWS_LIM : rows_req;
  assign cols_bound = (cols_req > COLS_LIM) ? COLS_LIM : cols_req;

  assign trow_w = {4'd0, trow};
  assign tcol_w = {4'd0, tcol};
  assign clip   = (trow_w >= rows_bound) || (tcol_w >= cols_bound);

  // Row and column fields side by side; valid only when the item is not clipped.
  assign addr = {trow_w[RAW-1:0], tcol_w[CAW-1:0]};

endmodule

`default_nettype wire

// ===== design/bbr_store.sv =====
// Frame store: one synchronous memory with one write and one registered read port,
// plus the clearing sweep that fills it with white after reset. Depends on bbr_pkg.
`default_nettype none

module bbr_store #(
  parameter int AW = 13
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  output logic               clearing
);

  localparam int DEPTH = 1 << AW;

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] clear_addr;

  // Clearing sweep, one entry per cycle from reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // Single write port, shared by the sweep and the datapath.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clear_addr] <= bbr_pkg::WHITE;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // The datapath never writes while the sweep owns the port.
  a_no_write_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !wr_en) else $error("store written during clearing sweep");

  // The sweep ends only after the last entry.
  a_clear_end: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clear_addr) == '1) else $error("clearing sweep ended early");

  // No read is issued while the store is being cleared.
  a_no_read_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !rd_en) else $error("store read during clearing sweep");

endmodule

`default_nettype wire

// ===== design/clipped_bitmap_blit_rop.sv =====
// Top level of the clipped byte-aligned bitmap blit with raster operation.
// Depends on bbr_pkg, bbr_regs, bbr_place and bbr_store.
//
//   channel   ports                                      handshake
//   item in   kind, row, byte_col, pixels                start high and busy low
//   result    data, clipped                              done, one cycle, no stall
//   config    psel penable pwrite paddr pwdata prdata    APB, pready always high
//
// At the accept edge the item is captured and the frame store read is issued; the
// modify state then writes the byte back and registers the result at its closing edge,
// and done is high in the cycle after that edge. Busy holds off new items meanwhile.
// After reset the store is swept to white, one byte a cycle, over all 2**(RAW+CAW) bytes
// (8192 at the default size); busy stays high meanwhile, configuration is taken.
// Results cannot be held off, so the block never waits on the receiver.
`default_nettype none

module clipped_bitmap_blit_rop #(
  parameter int MAX_ROWS      = bbr_pkg::DEF_MAX_ROWS,
  parameter int MAX_ROW_BYTES = bbr_pkg::DEF_MAX_ROW_BYTES
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           kind,
  input  wire logic [7:0]                     row,
  input  wire logic [4:0]                     byte_col,
  input  wire logic [7:0]                     pixels,
  output logic                                done,
  output logic      [7:0]                     data,
  output logic                                clipped,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bbr_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [bbr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [bbr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready
);

  localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CAW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int AW  = RAW + CAW;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_MODIFY = 2'b10
  } state_t;

  state_t        state;
  state_t        state_next;
  bbr_pkg::cfg_t cfg;
  logic          accept;
  logic          place_clip;
  logic [AW-1:0] place_addr;
  logic          clearing;
  logic [7:0]    rd_data;
  logic          wr_en;
  logic [7:0]    new_byte;

  // Item held during its read-modify-write.
  logic          kind_q;
  logic          clip_q;
  logic [7:0]    pixels_q;
  logic [AW-1:0] addr_q;

  // Configuration registers.
  bbr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Placement and clipping of the incoming item.
  bbr_place #(
    .MAX_ROWS      (MAX_ROWS),
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .RAW           (RAW),
    .CAW           (CAW)
  ) u_place (
    .kind     (kind),
    .row      (row),
    .byte_col (byte_col),
    .cfg      (cfg),
    .clip     (place_clip),
    .addr     (place_addr)
  );

  // Frame store.
  bbr_store #(
    .AW (AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (place_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (addr_q),
    .wr_data  (new_byte),
    .clearing (clearing)
  );

  assign busy   = clearing || (state == ST_MODIFY);
  assign accept = start && !busy;

  // Sequencer: idle, then a single modify state per item.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_MODIFY;
      ST_MODIFY: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the item at the accept edge.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q   <= kind;
      clip_q   <= place_clip;
      pixels_q <= pixels;
      addr_q   <= place_addr;
    end
  end

  // Modify and write back; reads leave the store unchanged.
  always_comb begin
    if (kind_q == bbr_pkg::KIND_DRAW) begin
      new_byte = bbr_pkg::rop_apply(cfg.raster_op, rd_data, pixels_q);
    end else begin
      new_byte = rd_data;
    end
  end

  assign wr_en = (state == ST_MODIFY) && !clip_q && (kind_q == bbr_pkg::KIND_DRAW);

  // Result register, shown for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_MODIFY);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MODIFY) begin
      data    <= clip_q ? 8'd0 : new_byte;
      clipped <= clip_q;
    end
  end

  // Every accepted item yields its result once its modify state has passed.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done) else $error("result missing after accepted item");

  // A result appears only after a modify cycle.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_MODIFY)) else $error("result without an item");

  // A clipped result carries zero data.
  a_clip_zero: assert property (@(posedge clk) disable iff (rst)
    (done && clipped) |-> (data == 8'd0)) else $error("clipped result with data");

  // Clipped items never reach the store.
  a_clip_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MODIFY && clip_q) |-> !wr_en) else $error("clipped item written");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for clipped_bitmap_blit_rop: directed and random blit items
// checked against a frame store predictor. Depends on bbr_pkg and the design sources.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ROWS        = bbr_pkg::DEF_MAX_ROWS;
  localparam int MAX_ROW_BYTES   = bbr_pkg::DEF_MAX_ROW_BYTES;
  localparam int STORE_BYTES     = MAX_ROWS * MAX_ROW_BYTES;
  localparam int PIXELS_PER_BYTE = 8;
  localparam int REG_COUNT       = 5;
  localparam int REG_SLOTS       = 8;
  localparam logic [1:0] ROP_KEEP = 2'd3;
  localparam int WATCHDOG_LIMIT  = 40000;
  localparam int RANDOM_PHASES   = 9;
  localparam int PHASE_ITEMS     = 150;

  typedef struct packed {
    logic [7:0] data;
    logic       clipped;
  } blit_result_t;

  // Predicts the byte each item leaves in the frame store and checks results in order.
  class frame_predictor;
    logic [7:0]    frame [STORE_BYTES];
    bbr_pkg::cfg_t cfg;
    blit_result_t  expected_bytes[$];
    int            errors;

    function new();
      foreach (frame[i]) frame[i] = bbr_pkg::WHITE;
      cfg.start_row        = 8'd0;
      cfg.start_col_pixels = 8'd0;
      cfg.raster_op        = bbr_pkg::ROP_REPLACE;
      cfg.target_rows      = bbr_pkg::RST_TARGET_ROWS;
      cfg.target_row_bytes = bbr_pkg::RST_TARGET_ROW_BYTES;
      errors = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] value);
      case (idx)
        bbr_pkg::REG_START_ROW:        cfg.start_row        = value[7:0];
        bbr_pkg::REG_START_COL_PIXELS: cfg.start_col_pixels = value[7:0];
        bbr_pkg::REG_RASTER_OP:        cfg.raster_op        = value[1:0];
        bbr_pkg::REG_TARGET_ROWS:      cfg.target_rows      = value[8:0];
        bbr_pkg::REG_TARGET_ROW_BYTES: cfg.target_row_bytes = value[5:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic k, logic [7:0] r, logic [4:0] c, logic [7:0] pix);
      int           trow;
      int           tcol;
      int           rows_lim;
      int           cols_lim;
      int           addr;
      logic [7:0]   v;
      blit_result_t res;
      rows_lim = (cfg.target_rows > MAX_ROWS) ? MAX_ROWS : int'(cfg.target_rows);
      cols_lim = (cfg.target_row_bytes > MAX_ROW_BYTES) ? MAX_ROW_BYTES
                                                        : int'(cfg.target_row_bytes);
      trow = r;
      tcol = c;
      // Draws are offset into the target; reads address it directly.
      if (k == bbr_pkg::KIND_DRAW) begin
        trow = int'(r) + int'(cfg.start_row);
        tcol = int'(c) + int'(cfg.start_col_pixels) / PIXELS_PER_BYTE;
      end
      if (trow >= rows_lim || tcol >= cols_lim) begin
        res.data    = 8'd0;
        res.clipped = 1'b1;
      end else begin
        addr = trow * MAX_ROW_BYTES + tcol;
        v = frame[addr];
        if (k == bbr_pkg::KIND_DRAW) begin
          case (cfg.raster_op)
            bbr_pkg::ROP_REPLACE: v = pix;
            bbr_pkg::ROP_AND:     v = v & pix;
            bbr_pkg::ROP_OR:      v = v | pix;
            default:              ;
          endcase
          frame[addr] = v;
        end
        res.data    = v;
        res.clipped = 1'b0;
      end
      expected_bytes.push_back(res);
    endfunction

    function void check_result(logic [7:0] got_data, logic got_clipped);
      blit_result_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: result with no item outstanding: data %02h clipped %0d",
                 $time, got_data, got_clipped);
        return;
      end
      want = expected_bytes.pop_front();
      if (want.data !== got_data) begin
        errors++;
        $display("%0t: data mismatch: expected %02h actual %02h", $time, want.data, got_data);
      end
      if (want.clipped !== got_clipped) begin
        errors++;
        $display("%0t: clipped mismatch: expected %0d actual %0d",
                 $time, want.clipped, got_clipped);
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           start;
  logic                           busy;
  logic                           kind;
  logic [7:0]                     row;
  logic [4:0]                     byte_col;
  logic [7:0]                     pixels;
  logic                           done;
  logic [7:0]                     data;
  logic                           clipped;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [bbr_pkg::CFG_ADDR_W-1:0] paddr;
  logic [bbr_pkg::CFG_DATA_W-1:0] pwdata;
  logic [bbr_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  frame_predictor blit_model;
  int             idle_cycles = 0;

  clipped_bitmap_blit_rop dut (.*);

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Check results and record accepted items; count cycles without any transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) blit_model.check_result(data, clipped);
      if (start && !busy) blit_model.note_item(kind, row, byte_col, pixels);
    end
    if ((start && !busy) || done || (psel && penable && pwrite)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog.
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("FAIL clipped_bitmap_blit_rop");
    $finish;
  end

  // Present one item and hold it until the block takes it.
  task automatic send_item(input logic k, input logic [7:0] r, input logic [4:0] c,
                           input logic [7:0] pix);
    start    <= 1'b1;
    kind     <= k;
    row      <= r;
    byte_col <= c;
    pixels   <= pix;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stop sending and wait until every outstanding result has arrived.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (blit_model.expected_bytes.size() != 0) @(posedge clk);
  endtask

  // One register write: setup cycle, access cycle, then an idle cycle.
  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    blit_model.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] sr, input logic [7:0] scp, input logic [1:0] rop,
                            input logic [8:0] trows, input logic [5:0] tbytes);
    drain();
    apb_write(bbr_pkg::REG_START_ROW, 32'(sr));
    apb_write(bbr_pkg::REG_START_COL_PIXELS, 32'(scp));
    apb_write(bbr_pkg::REG_RASTER_OP, 32'(rop));
    apb_write(bbr_pkg::REG_TARGET_ROWS, 32'(trows));
    apb_write(bbr_pkg::REG_TARGET_ROW_BYTES, 32'(tbytes));
  endtask

  // Random items in bursts with random gaps; half the rows and half the columns fall in a
  // small hot area so that reads and read-modify-writes see bytes drawn earlier.
  task automatic run_random(input int count);
    int         burst;
    int         gap;
    logic       k;
    logic [7:0] r;
    logic [4:0] c;
    burst = $urandom_range(1, 24);
    for (int i = 0; i < count; i++) begin
      k = ($urandom_range(0, 9) < 6) ? bbr_pkg::KIND_DRAW : bbr_pkg::KIND_READ;
      r = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom());
      c = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 7)) : 5'($urandom());
      send_item(k, r, c, 8'($urandom()));
      burst--;
      if (burst == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2: gap = 0;
          9:       gap = $urandom_range(10, 40);
          default: gap = $urandom_range(1, 6);
        endcase
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 24);
      end
    end
  endtask

  initial begin
    logic [7:0] sr;
    logic [7:0] scp;
    logic [1:0] rop;
    logic [8:0] trows;
    logic [5:0] tbytes;
    blit_model = new();
    rst      <= 1'b1;
    start    <= 1'b0;
    kind     <= bbr_pkg::KIND_DRAW;
    row      <= 8'd0;
    byte_col <= 5'd0;
    pixels   <= 8'd0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // Let the clearing sweep finish.
    @(posedge clk);
    while (busy) @(posedge clk);

    // Reset configuration: fresh white store, corners of the target.
    send_item(bbr_pkg::KIND_READ, 8'd0, 5'd0, 8'h00);
    send_item(bbr_pkg::KIND_DRAW, 8'd255, 5'd31, 8'h00);
    send_item(bbr_pkg::KIND_READ, 8'd255, 5'd31, 8'hFF);
    send_item(bbr_pkg::KIND_DRAW, 8'd0, 5'd0, 8'hA5);

    // Offsets with AND: draws pushed past the bottom and the right edge are dropped.
    set_config(8'd10, 8'd15, bbr_pkg::ROP_AND, 9'd256, 6'd32);
    send_item(bbr_pkg::KIND_DRAW, 8'd250, 5'd0, 8'hFF);
    send_item(bbr_pkg::KIND_DRAW, 8'd0, 5'd31, 8'hFF);
    send_item(bbr_pkg::KIND_DRAW, 8'd0, 5'd0, 8'h0F);
    send_item(bbr_pkg::KIND_READ, 8'd10, 5'd1, 8'h00);

    // OR, then the unused operation that keeps the stored byte.
    set_config(8'd10, 8'd15, bbr_pkg::ROP_OR, 9'd256, 6'd32);
    send_item(bbr_pkg::KIND_DRAW, 8'd0, 5'd0, 8'hF0);
    set_config(8'd10, 8'd15, ROP_KEEP, 9'd256, 6'd32);
    send_item(bbr_pkg::KIND_DRAW, 8'd0, 5'd0, 8'h00);

    // Zero bounds clip every item.
    set_config(8'd0, 8'd0, bbr_pkg::ROP_REPLACE, 9'd0, 6'd32);
    send_item(bbr_pkg::KIND_READ, 8'd0, 5'd0, 8'h00);
    send_item(bbr_pkg::KIND_DRAW, 8'd0, 5'd0, 8'h55);
    set_config(8'd0, 8'd0, bbr_pkg::ROP_REPLACE, 9'd256, 6'd0);
    send_item(bbr_pkg::KIND_READ, 8'd0, 5'd0, 8'h00);

    // Bounds above the storage size and largest offsets.
    set_config(8'd255, 8'd255, bbr_pkg::ROP_REPLACE, 9'd511, 6'd63);
    send_item(bbr_pkg::KIND_DRAW, 8'd255, 5'd31, 8'h3C);
    send_item(bbr_pkg::KIND_DRAW, 8'd0, 5'd0, 8'h3C);
    send_item(bbr_pkg::KIND_DRAW, 8'd0, 5'd1, 8'h3C);
    send_item(bbr_pkg::KIND_READ, 8'd255, 5'd31, 8'h00);

    // Smallest target; a column offset below one byte is dropped.
    set_config(8'd0, 8'd7, bbr_pkg::ROP_REPLACE, 9'd1, 6'd1);
    send_item(bbr_pkg::KIND_DRAW, 8'd0, 5'd0, 8'h81);
    send_item(bbr_pkg::KIND_READ, 8'd1, 5'd0, 8'h00);
    send_item(bbr_pkg::KIND_READ, 8'd0, 5'd1, 8'h00);
    send_item(bbr_pkg::KIND_READ, 8'd0, 5'd0, 8'h00);

    // Random phases, each under a fresh random configuration.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      sr  = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 8)) : 8'($urandom());
      scp = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 71)) : 8'($urandom());
      rop = ($urandom_range(0, 7) == 0) ? ROP_KEEP : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 5))
        3:       trows = 9'($urandom_range(0, 511));
        4:       trows = 9'($urandom_range(1, 32));
        5:       trows = 9'd511;
        default: trows = bbr_pkg::RST_TARGET_ROWS;
      endcase
      case ($urandom_range(0, 5))
        3:       tbytes = 6'($urandom_range(0, 63));
        4:       tbytes = 6'($urandom_range(1, 8));
        5:       tbytes = 6'd63;
        default: tbytes = bbr_pkg::RST_TARGET_ROW_BYTES;
      endcase
      set_config(sr, scp, rop, trows, tbytes);
      // Writes to unused register slots must change nothing.
      if ($urandom_range(0, 2) == 0) begin
        apb_write(3'($urandom_range(REG_COUNT, REG_SLOTS - 1)), $urandom());
      end
      run_random(PHASE_ITEMS);
    end

    drain();
    repeat (8) @(posedge clk);
    if (blit_model.errors == 0 && blit_model.expected_bytes.size() == 0) begin
      $display("PASS clipped_bitmap_blit_rop");
    end else begin
      $display("FAIL clipped_bitmap_blit_rop");
    end
    $finish;
  end

endmodule

`default_nettype wire
